// File: hdl/rgbfc_pkg.sv
// Shared constants, phase codes and box-test functions for the color sensor readout.
`timescale 1ns / 1ps

package rgbfc_pkg;

  localparam int COUNT_BITS = 16;
  localparam int TICK_BITS  = 16;
  localparam int GATE_BITS  = 16;
  localparam int OUT_BITS   = 16;
  localparam int MASK_BITS  = 8;
  localparam int COLOR_BITS = 4;
  localparam int PINS_BITS  = 4;
  localparam int CMP_BITS   = 32;

  localparam logic [GATE_BITS-1:0] GATE_RESET = 16'd400;

  localparam logic [1:0] PH_RED   = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_BLUE  = 2'd2;

  localparam logic [PINS_BITS-1:0] PINS_RED   = 4'h1;
  localparam logic [PINS_BITS-1:0] PINS_GREEN = 4'hD;
  localparam logic [PINS_BITS-1:0] PINS_BLUE  = 4'h9;

  localparam logic [COLOR_BITS-1:0] COLOR_READY = 4'd0;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CMP_BITS-1:0]   wide_t;

  function automatic logic in_window(input wide_t v, input wide_t lo, input wide_t hi);
    in_window = (v > lo) && (v < hi);
  endfunction

  function automatic logic box(input wide_t r, input wide_t g, input wide_t b,
                               input wide_t rl, input wide_t rh,
                               input wide_t gl, input wide_t gh,
                               input wide_t bl, input wide_t bh);
    box = in_window(r, rl, rh) && in_window(g, gl, gh) && in_window(b, bl, bh);
  endfunction

endpackage

// File: hdl/rgbfc_classify.sv
// Box tests that turn one frame of red, green and blue counts into a match mask.
`timescale 1ns / 1ps

module rgbfc_classify import rgbfc_pkg::*; (
  input  count_t               red,
  input  count_t               green,
  input  count_t               blue,
  output logic [MASK_BITS-1:0] mask
);

  wide_t r;
  wide_t g;
  wide_t b;

  assign r = CMP_BITS'(red);
  assign g = CMP_BITS'(green);
  assign b = CMP_BITS'(blue);

  always_comb begin
    mask = '0;
    // The first four boxes are chosen by the red count alone.
    if (in_window(r, 32'd0, 32'd1100)) begin
      mask[0] = box(r, g, b, 32'd0, 32'd1100, 32'd0, 32'd1100, 32'd0, 32'd1300);
    end else if (in_window(r, 32'd4500, 32'd7000)) begin
      mask[1] = box(r, g, b, 32'd4500, 32'd7000, 32'd4600, 32'd7000, 32'd5800, 32'd8100);
    end else if (in_window(r, 32'd3400, 32'd5200)) begin
      mask[2] = box(r, g, b, 32'd3400, 32'd5200, 32'd1100, 32'd2500, 32'd1700, 32'd3100);
    end else if (in_window(r, 32'd1500, 32'd2800)) begin
      mask[3] = box(r, g, b, 32'd1500, 32'd2800, 32'd1500, 32'd2900, 32'd1300, 32'd2700);
    end
    mask[4] = box(r, g, b, 32'd1700, 32'd3700, 32'd2200, 32'd3800, 32'd3800, 32'd6300);
    mask[5] = box(r, g, b, 32'd1900, 32'd3600, 32'd1900, 32'd3100, 32'd2900, 32'd4300);
    mask[6] = box(r, g, b, 32'd5000, 32'd8000, 32'd3000, 32'd6000, 32'd2000, 32'd4500);
    mask[7] = box(r, g, b, 32'd1100, 32'd2400, 32'd1100, 32'd2400, 32'd1300, 32'd2400);
  end

endmodule

// File: hdl/rgb_frequency_color_classifier_core.sv
// Top level of the color sensor readout: input register, phase counters and result register.
`timescale 1ns / 1ps

// Each input word carries one clock of gate_tick and sensor_edge events. The block
// counts sensor edges per color phase until gate_length ticks have passed, stores
// the count, and steps red, green, blue. The word that ends the blue phase runs the
// box tests, updates the match mask and shown color, and is marked with m_tlast.
// Every input word yields exactly one output word with the pins of the phase it
// was counted in and the latest mask, color and counts.
// An input word is taken into an input register, then passes through the counter
// and box-test logic into the output register. One word is accepted every cycle
// while the receiver takes the output words; the rate is set by the phase counters,
// which take a new word whenever the output register is free.
// When the receiver stalls, the output register holds its word and the input
// register fills; s_tready then falls until the output word is taken.
// Reset clears the phase to red, all counters, the mask and the shown color, and
// loads gate_length with 400. cfg_we writes gate_length at once.

module rgb_frequency_color_classifier_core import rgbfc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [GATE_BITS-1:0] cfg_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // gate_tick, sensor_edge, zero fill
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata,   // filter_pins, match_mask, shown_color,
                                          // last_red, last_green, last_blue
  output logic                 m_tlast    // frame_done
);

  logic [GATE_BITS-1:0]  gate_length;
  logic                  in_valid;
  logic                  in_tick;
  logic                  in_edge;
  logic [1:0]            phase;
  logic [TICK_BITS-1:0]  tick_count;
  count_t                edge_count;
  count_t                red_count;
  count_t                green_count;
  count_t                blue_count;
  logic [COLOR_BITS-1:0] color_shown;
  logic [MASK_BITS-1:0]  mask_held;

  logic                  advance;
  logic                  out_free;
  logic [TICK_BITS-1:0]  tick_inc;
  count_t                edge_inc;
  logic                  window_end;
  logic [MASK_BITS-1:0]  mask_new;
  logic [PINS_BITS-1:0]  pins;
  logic [1:0]            phase_next;
  logic [TICK_BITS-1:0]  tick_count_next;
  count_t                edge_count_next;
  count_t                red_count_next;
  count_t                green_count_next;
  count_t                blue_count_next;
  logic [COLOR_BITS-1:0] color_shown_next;
  logic [MASK_BITS-1:0]  mask_held_next;
  logic                  done;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  assign tick_inc   = tick_count + 1'b1;
  assign edge_inc   = in_edge ? edge_count + 1'b1 : edge_count;
  assign window_end = in_tick && (tick_inc == gate_length);

  rgbfc_classify u_classify (
    .red   (red_count),
    .green (green_count),
    .blue  (edge_inc),
    .mask  (mask_new)
  );

  always_comb begin
    case (phase)
      PH_GREEN: pins = PINS_GREEN;
      PH_BLUE:  pins = PINS_BLUE;
      default:  pins = PINS_RED;
    endcase
  end

  always_comb begin
    phase_next       = phase;
    tick_count_next  = in_tick ? tick_inc : tick_count;
    edge_count_next  = edge_inc;
    red_count_next   = red_count;
    green_count_next = green_count;
    blue_count_next  = blue_count;
    mask_held_next   = mask_held;
    color_shown_next = color_shown;
    done             = 1'b0;
    if (window_end) begin
      tick_count_next = '0;
      edge_count_next = '0;
      case (phase)
        PH_GREEN: begin
          green_count_next = edge_inc;
          phase_next       = PH_BLUE;
        end
        PH_BLUE: begin
          blue_count_next = edge_inc;
          phase_next      = PH_RED;
          mask_held_next  = mask_new;
          done            = 1'b1;
          // The highest matched box wins; nothing matched keeps the old color.
          for (int k = 0; k < MASK_BITS; k++) begin
            if (mask_new[k]) begin
              color_shown_next = COLOR_BITS'(k + 1);
            end
          end
        end
        default: begin
          red_count_next = edge_inc;
          phase_next     = PH_GREEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_length <= GATE_RESET;
    end else if (cfg_we) begin
      gate_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_tick <= s_tdata[0];
      in_edge <= s_tdata[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_RED;
      tick_count  <= '0;
      edge_count  <= '0;
      red_count   <= '0;
      green_count <= '0;
      blue_count  <= '0;
      color_shown <= COLOR_READY;
      mask_held   <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      edge_count  <= edge_count_next;
      red_count   <= red_count_next;
      green_count <= green_count_next;
      blue_count  <= blue_count_next;
      color_shown <= color_shown_next;
      mask_held   <= mask_held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata[3:0]   <= pins;
      m_tdata[11:4]  <= mask_held_next;
      m_tdata[15:12] <= color_shown_next;
      m_tdata[31:16] <= OUT_BITS'(red_count_next);
      m_tdata[47:32] <= OUT_BITS'(green_count_next);
      m_tdata[63:48] <= OUT_BITS'(blue_count_next);
      m_tlast        <= done;
    end
  end

endmodule
